[rtl/core/jxs_pkg.sv]
// shared types, constants and helpers of the exif segment stripper
`default_nettype none

package jxs_pkg;

    localparam int HOLD_DEPTH     = 10;
    localparam int HOLD_IDX_W     = $clog2(HOLD_DEPTH);
    localparam int HOLD_CNT_W     = $clog2(HOLD_DEPTH + 1);
    localparam int CMD_FIFO_DEPTH = 4;

    localparam logic [7:0] MARK_PREFIX = 8'hFF;
    localparam logic [7:0] MARK_SOI    = 8'hD8;
    localparam logic [7:0] MARK_EOI    = 8'hD9;
    localparam logic [7:0] MARK_SOS    = 8'hDA;
    localparam logic [7:0] MARK_TEM    = 8'h01;
    localparam logic [7:0] MARK_RST0   = 8'hD0;
    localparam logic [7:0] MARK_RST7   = 8'hD7;
    localparam logic [7:0] MARK_APP1   = 8'hE1;

    localparam logic [15:0] MIN_SEG_LEN  = 16'd2;
    localparam logic [15:0] MIN_EXIF_LEN = 16'd8;

    localparam int EXIF_SIG_LEN = 6;
    localparam int SIG_OFFSET   = HOLD_DEPTH - EXIF_SIG_LEN;
    localparam logic [0:EXIF_SIG_LEN-1][7:0] EXIF_SIG =
        '{8'h45, 8'h78, 8'h69, 8'h66, 8'h00, 8'h00};

    typedef logic [HOLD_DEPTH-1:0][7:0] jxs_hold_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } jxs_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       end_of_file;
        logic       status;
        logic       run_last;
    } jxs_out_t;

    typedef struct packed {
        jxs_hold_t             data;
        logic [HOLD_CNT_W-1:0] n_data;
        logic                  has_status;
        logic                  status;
    } jxs_cmd_t;

    // held bytes from the signature offset plus the incoming byte as the last one
    function automatic logic exif_sig_match(input jxs_hold_t held, input logic [7:0] d);
        logic ok;
        ok = (d == EXIF_SIG[EXIF_SIG_LEN-1]);
        for (int i = 0; i < EXIF_SIG_LEN - 1; i++) begin
            if (held[SIG_OFFSET + i] != EXIF_SIG[i]) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

`default_nettype wire

[rtl/core/jxs_front.sv]
// front end: marker parser that turns each input byte that releases data or ends the file into an output command
`default_nettype none

module jxs_front
    import jxs_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire jxs_in_t  s_data,
    input  wire logic     fifo_full,
    output logic          push,
    output jxs_cmd_t      cmd
);

    typedef enum logic [9:0] {
        PH_FIRST   = 10'b00_0000_0001,
        PH_SECOND  = 10'b00_0000_0010,
        PH_PASS    = 10'b00_0000_0100,
        PH_MARK_FF = 10'b00_0000_1000,
        PH_MARK_ID = 10'b00_0001_0000,
        PH_LEN_HI  = 10'b00_0010_0000,
        PH_LEN_LO  = 10'b00_0100_0000,
        PH_SIG     = 10'b00_1000_0000,
        PH_BODY    = 10'b01_0000_0000,
        PH_ERR     = 10'b10_0000_0000
    } jxs_phase_t;

    jxs_phase_t            phase_reg, phase_next;
    jxs_hold_t             hold_reg, hold_next;
    logic [HOLD_CNT_W-1:0] hold_cnt_reg, hold_cnt_next;
    logic [15:0]           remain_reg, remain_next;
    logic [7:0]            len_hi_reg, len_hi_next;
    logic                  app1_reg, app1_next;
    logic                  drop_reg, drop_next;
    logic                  err_reg, err_next;

    logic                  accept;
    logic [7:0]            d;
    logic                  fin;
    logic                  err;
    logic                  hold_wr;
    logic [HOLD_CNT_W-1:0] out_n;
    logic [15:0]           seg_len;
    logic [15:0]           remain_dec;
    logic                  standalone;
    jxs_hold_t             cmd_data;

    assign s_ready = !fifo_full;
    assign accept  = s_valid && s_ready;
    assign d       = s_data.data_byte;
    assign fin     = s_data.last_byte;
    assign seg_len = {len_hi_reg, d};

    assign remain_dec = (remain_reg != 16'd0) ? remain_reg - 16'd1 : remain_reg;
    assign standalone = (d == MARK_TEM) || (d >= MARK_RST0 && d <= MARK_RST7);

    always_comb begin
        cmd_data = hold_reg;
        if (hold_cnt_reg < HOLD_CNT_W'(HOLD_DEPTH)) begin
            cmd_data[hold_cnt_reg[HOLD_IDX_W-1:0]] = d;
        end
    end

    always_comb begin
        phase_next    = phase_reg;
        hold_next     = hold_reg;
        hold_cnt_next = hold_cnt_reg;
        remain_next   = remain_reg;
        len_hi_next   = len_hi_reg;
        app1_next     = app1_reg;
        drop_next     = drop_reg;
        err_next      = err_reg;
        err           = 1'b0;
        hold_wr       = 1'b0;
        out_n         = '0;

        unique case (phase_reg)
            PH_FIRST: begin
                if (d == MARK_PREFIX) begin
                    hold_wr    = 1'b1;
                    phase_next = PH_SECOND;
                end else begin
                    out_n      = HOLD_CNT_W'(1);
                    phase_next = PH_PASS;
                end
            end
            PH_SECOND: begin
                if (d == MARK_SOI && fin) begin
                    err = 1'b1;
                end else begin
                    out_n         = hold_cnt_reg + HOLD_CNT_W'(1);
                    hold_cnt_next = '0;
                    phase_next    = (d == MARK_SOI) ? PH_MARK_FF : PH_PASS;
                end
            end
            PH_PASS: begin
                out_n = HOLD_CNT_W'(1);
            end
            PH_MARK_FF: begin
                if (d != MARK_PREFIX) begin
                    err = 1'b1;
                end else begin
                    hold_wr    = 1'b1;
                    phase_next = PH_MARK_ID;
                end
            end
            PH_MARK_ID: begin
                app1_next = (d == MARK_APP1);
                if (d == MARK_EOI || d == MARK_SOS) begin
                    out_n         = hold_cnt_reg + HOLD_CNT_W'(1);
                    hold_cnt_next = '0;
                    phase_next    = PH_PASS;
                end else if (standalone) begin
                    out_n         = hold_cnt_reg + HOLD_CNT_W'(1);
                    hold_cnt_next = '0;
                    phase_next    = PH_MARK_FF;
                end else begin
                    hold_wr    = 1'b1;
                    phase_next = PH_LEN_HI;
                end
            end
            PH_LEN_HI: begin
                hold_wr     = 1'b1;
                len_hi_next = d;
                phase_next  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                hold_wr = 1'b1;
                if (seg_len < MIN_SEG_LEN) begin
                    err = 1'b1;
                end else begin
                    remain_next = seg_len - MIN_SEG_LEN;
                    drop_next   = 1'b0;
                    if (app1_reg && seg_len >= MIN_EXIF_LEN) begin
                        phase_next = PH_SIG;
                    end else begin
                        out_n         = hold_cnt_reg + HOLD_CNT_W'(1);
                        hold_cnt_next = '0;
                        hold_wr       = 1'b0;
                        phase_next    = (seg_len != MIN_SEG_LEN) ? PH_BODY : PH_MARK_FF;
                    end
                end
            end
            PH_SIG: begin
                hold_wr     = 1'b1;
                remain_next = remain_dec;
                if (hold_cnt_reg == HOLD_CNT_W'(HOLD_DEPTH - 1)) begin
                    hold_wr       = 1'b0;
                    hold_cnt_next = '0;
                    if (exif_sig_match(hold_reg, d)) begin
                        drop_next = 1'b1;
                    end else begin
                        out_n = hold_cnt_reg + HOLD_CNT_W'(1);
                    end
                    phase_next = (remain_dec != 16'd0) ? PH_BODY : PH_MARK_FF;
                end
            end
            PH_BODY: begin
                if (!drop_reg) begin
                    out_n = HOLD_CNT_W'(1);
                end
                remain_next = remain_dec;
                if (remain_dec == 16'd0) begin
                    phase_next = PH_MARK_FF;
                end
            end
            PH_ERR: begin
            end
            default: begin
                phase_next = PH_ERR;
            end
        endcase

        if (hold_wr && hold_cnt_reg < HOLD_CNT_W'(HOLD_DEPTH)) begin
            hold_next[hold_cnt_reg[HOLD_IDX_W-1:0]] = d;
            hold_cnt_next = hold_cnt_reg + HOLD_CNT_W'(1);
        end

        if (err) begin
            err_next      = 1'b1;
            hold_cnt_next = '0;
            out_n         = '0;
            phase_next    = PH_ERR;
        end

        if (fin) begin
            if (phase_next == PH_SECOND) begin
                out_n = hold_cnt_next;
            end else if (phase_next == PH_MARK_ID || phase_next == PH_LEN_HI ||
                         phase_next == PH_LEN_LO || phase_next == PH_SIG ||
                         phase_next == PH_BODY) begin
                err_next = 1'b1;
            end
        end
    end

    always_comb begin
        cmd.data       = cmd_data;
        cmd.n_data     = out_n;
        cmd.has_status = fin;
        cmd.status     = err_next;
    end

    assign push = accept && (fin || out_n != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_FIRST;
            hold_cnt_reg <= '0;
            remain_reg   <= '0;
            len_hi_reg   <= '0;
            app1_reg     <= 1'b0;
            drop_reg     <= 1'b0;
            err_reg      <= 1'b0;
        end else if (accept) begin
            if (fin) begin
                phase_reg    <= PH_FIRST;
                hold_cnt_reg <= '0;
                remain_reg   <= '0;
                len_hi_reg   <= '0;
                app1_reg     <= 1'b0;
                drop_reg     <= 1'b0;
                err_reg      <= 1'b0;
            end else begin
                phase_reg    <= phase_next;
                hold_cnt_reg <= hold_cnt_next;
                remain_reg   <= remain_next;
                len_hi_reg   <= len_hi_next;
                app1_reg     <= app1_next;
                drop_reg     <= drop_next;
                err_reg      <= err_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            hold_reg <= hold_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/jxs_cmd_fifo.sv]
// command queue between the parser and the output sequencer
`default_nettype none

module jxs_cmd_fifo
    import jxs_pkg::*;
#(
    parameter int DEPTH = CMD_FIFO_DEPTH
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     push,
    input  wire jxs_cmd_t wr_cmd,
    output logic          full,
    input  wire logic     pop,
    output jxs_cmd_t      rd_cmd,
    output logic          empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    jxs_cmd_t         mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_cmd  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

[rtl/core/jxs_back.sv]
// back end: expands each command into result transactions through an output register
`default_nettype none

module jxs_back
    import jxs_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire jxs_cmd_t head,
    input  wire logic     head_empty,
    output logic          pop,
    output logic          m_valid,
    input  wire logic     m_ready,
    output jxs_out_t      m_data
);

    logic [HOLD_CNT_W-1:0] idx_reg;
    logic [HOLD_CNT_W:0]   total;
    logic                  m_valid_reg;
    jxs_out_t              m_data_reg;
    jxs_out_t              item;
    logic                  advance;
    logic                  is_last;

    assign total   = {1'b0, head.n_data} + {{HOLD_CNT_W{1'b0}}, head.has_status};
    assign is_last = ({1'b0, idx_reg} + (HOLD_CNT_W + 1)'(1)) == total;
    assign advance = !head_empty && (!m_valid_reg || m_ready);
    assign pop     = advance && is_last;

    always_comb begin
        if (idx_reg < head.n_data) begin
            item.out_byte    = head.data[idx_reg[HOLD_IDX_W-1:0]];
            item.byte_valid  = 1'b1;
            item.end_of_file = 1'b0;
            item.status      = 1'b0;
        end else begin
            item.out_byte    = 8'h00;
            item.byte_valid  = 1'b0;
            item.end_of_file = 1'b1;
            item.status      = head.status;
        end
        item.run_last = is_last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            idx_reg     <= '0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
            idx_reg     <= is_last ? '0 : idx_reg + HOLD_CNT_W'(1);
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= item;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

[rtl/core/jpeg_exif_segment_stripper_unit.sv]
// top level of the jpeg exif segment stripper
//
// usage: bytes of an image file enter on the s_ channel (data_byte, last_byte)
// one transaction per byte; the stripped file leaves on the m_ channel.
// every file ends with one status-only transaction (byte_valid 0, end_of_file 1)
// whose status bit is 1 on a decode error; data already delivered for such a
// file must be discarded. run_last marks the last result of an input byte.
// the results of a byte pass through the command queue and then the output register.
// throughput: one byte per cycle in steady flow. a byte that releases held
// header bytes yields up to ten data transactions plus the end-of-file one,
// one per cycle from the output sequencer while m_ready allows; the parser keeps accepting until
// the command queue (FIFO_DEPTH entries) is full, then s_ready falls.
// a stall on m_ready holds the output register and backs up into the queue.
// reset (aresetn low, synchronous) empties the queue, drops any pending
// result and returns the parser to the start of a file.
`default_nettype none

module jpeg_exif_segment_stripper_unit
    import jxs_pkg::*;
#(
    parameter int FIFO_DEPTH = CMD_FIFO_DEPTH
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire jxs_in_t  s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output jxs_out_t      m_data
);

    jxs_cmd_t wr_cmd;
    jxs_cmd_t rd_cmd;
    logic     push;
    logic     pop;
    logic     full;
    logic     empty;

    jxs_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .fifo_full (full),
        .push      (push),
        .cmd       (wr_cmd)
    );

    jxs_cmd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_cmd  (wr_cmd),
        .full    (full),
        .pop     (pop),
        .rd_cmd  (rd_cmd),
        .empty   (empty)
    );

    jxs_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (rd_cmd),
        .head_empty (empty),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

`default_nettype wire

[dv/jpeg_exif_segment_stripper_unit_checker.sv]
// checker for the exif segment stripper: predicts the stripped stream and compares results
`timescale 1ns / 1ps

module jpeg_exif_segment_stripper_unit_checker
    import jxs_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    input  wire logic     s_ready,
    input  wire jxs_in_t  s_data,
    input  wire logic     m_valid,
    input  wire logic     m_ready,
    input  wire jxs_out_t m_data,
    output int            mismatches,
    output int            pending
);

    typedef enum logic [3:0] {
        P_FIRST, P_SECOND, P_PASS, P_MARK_FF, P_MARK_ID,
        P_LEN_HI, P_LEN_LO, P_SIG, P_BODY, P_ERR
    } parse_phase_e;

    jxs_out_t     expected_out[$];
    jxs_out_t     byte_run[$];
    parse_phase_e phase;
    logic [7:0]   held [HOLD_DEPTH];
    int           held_n;
    logic [15:0]  seg_left;
    logic [15:0]  seg_len;
    logic [7:0]   marker;
    logic         dropping;
    logic         decode_err;

    initial begin
        mismatches = 0;
        pending    = 0;
    end

    function automatic void put_byte(input logic [7:0] b);
        jxs_out_t r;
        r            = '0;
        r.out_byte   = b;
        r.byte_valid = 1'b1;
        byte_run.push_back(r);
    endfunction

    function automatic void hold_byte(input logic [7:0] b);
        if (held_n < HOLD_DEPTH) begin
            held[held_n] = b;
            held_n++;
        end
    endfunction

    function automatic void flush_held();
        for (int i = 0; i < held_n; i++) begin
            put_byte(held[i]);
        end
        held_n = 0;
    endfunction

    function automatic void clear_parser();
        phase      = P_FIRST;
        held_n     = 0;
        seg_left   = '0;
        seg_len    = '0;
        marker     = '0;
        dropping   = 1'b0;
        decode_err = 1'b0;
    endfunction

    task automatic predict_strip(input jxs_in_t t);
        logic [7:0] d;
        logic       fin;
        logic       err;
        logic       sig_ok;
        jxs_out_t   r;
        d   = t.data_byte;
        fin = t.last_byte;
        err = 1'b0;
        byte_run.delete();
        case (phase)
            P_FIRST: begin
                if (d == MARK_PREFIX) begin
                    hold_byte(d);
                    phase = P_SECOND;
                end else begin
                    put_byte(d);
                    phase = P_PASS;
                end
            end
            P_SECOND: begin
                if (d == MARK_SOI) begin
                    if (fin) begin
                        err = 1'b1;
                    end else begin
                        flush_held();
                        put_byte(d);
                        phase = P_MARK_FF;
                    end
                end else begin
                    flush_held();
                    put_byte(d);
                    phase = P_PASS;
                end
            end
            P_PASS: begin
                put_byte(d);
            end
            P_MARK_FF: begin
                if (d != MARK_PREFIX) begin
                    err = 1'b1;
                end else begin
                    held_n = 0;
                    hold_byte(d);
                    phase = P_MARK_ID;
                end
            end
            P_MARK_ID: begin
                marker = d;
                if (d == MARK_EOI || d == MARK_SOS) begin
                    flush_held();
                    put_byte(d);
                    phase = P_PASS;
                end else if (d == MARK_TEM || (d >= MARK_RST0 && d <= MARK_RST7)) begin
                    flush_held();
                    put_byte(d);
                    phase = P_MARK_FF;
                end else begin
                    hold_byte(d);
                    phase = P_LEN_HI;
                end
            end
            P_LEN_HI: begin
                hold_byte(d);
                seg_len = {d, 8'h00};
                phase   = P_LEN_LO;
            end
            P_LEN_LO: begin
                hold_byte(d);
                seg_len[7:0] = d;
                if (seg_len < MIN_SEG_LEN) begin
                    err = 1'b1;
                end else begin
                    seg_left = seg_len - MIN_SEG_LEN;
                    dropping = 1'b0;
                    if (marker == MARK_APP1 && seg_len >= MIN_EXIF_LEN) begin
                        phase = P_SIG;
                    end else begin
                        flush_held();
                        phase = (seg_left != 0) ? P_BODY : P_MARK_FF;
                    end
                end
            end
            P_SIG: begin
                hold_byte(d);
                if (seg_left != 0) begin
                    seg_left--;
                end
                if (held_n >= HOLD_DEPTH) begin
                    sig_ok = 1'b1;
                    for (int i = 0; i < EXIF_SIG_LEN; i++) begin
                        if (held[SIG_OFFSET + i] != EXIF_SIG[i]) begin
                            sig_ok = 1'b0;
                        end
                    end
                    if (sig_ok) begin
                        dropping = 1'b1;
                        held_n   = 0;
                    end else begin
                        flush_held();
                    end
                    phase = (seg_left != 0) ? P_BODY : P_MARK_FF;
                end
            end
            P_BODY: begin
                if (!dropping) begin
                    put_byte(d);
                end
                if (seg_left != 0) begin
                    seg_left--;
                end
                if (seg_left == 0) begin
                    phase = P_MARK_FF;
                end
            end
            default: begin
            end
        endcase

        if (err) begin
            decode_err = 1'b1;
            held_n     = 0;
            phase      = P_ERR;
        end

        if (fin) begin
            case (phase)
                P_SECOND: begin
                    flush_held();
                end
                P_MARK_ID, P_LEN_HI, P_LEN_LO, P_SIG, P_BODY: begin
                    decode_err = 1'b1;
                end
                default: begin
                end
            endcase
            r             = '0;
            r.end_of_file = 1'b1;
            r.status      = decode_err;
            byte_run.push_back(r);
            clear_parser();
        end

        if (byte_run.size() > 0) begin
            byte_run[byte_run.size() - 1].run_last = 1'b1;
        end
        foreach (byte_run[k]) begin
            expected_out.push_back(byte_run[k]);
        end
    endtask

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        jxs_out_t want;
        if (!aresetn) begin
            clear_parser();
            expected_out.delete();
        end else begin
            if (s_valid && s_ready) begin
                predict_strip(s_data);
            end
            if (m_valid && m_ready) begin
                if (expected_out.size() == 0) begin
                    $error("unexpected transaction: out_byte %0d byte_valid %0d end_of_file %0d",
                           m_data.out_byte, m_data.byte_valid, m_data.end_of_file);
                    mismatches++;
                end else begin
                    want = expected_out.pop_front();
                    check_field("out_byte", want.out_byte, m_data.out_byte);
                    check_field("byte_valid", want.byte_valid, m_data.byte_valid);
                    check_field("end_of_file", want.end_of_file, m_data.end_of_file);
                    check_field("status", want.status, m_data.status);
                    check_field("run_last", want.run_last, m_data.run_last);
                end
            end
        end
        pending = expected_out.size();
    end

endmodule

[dv/jpeg_exif_segment_stripper_unit_test.sv]
// testbench top for the exif segment stripper: stimulus, clock, reset and verdict
`timescale 1ns / 1ps

module jpeg_exif_segment_stripper_unit_test;
    import jxs_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int TOTAL_BYTES = 150;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    jxs_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    jxs_out_t m_data;

    int         mismatches;
    int         pending;
    int         cycles = 0;
    int         sent   = 0;
    logic       steady = 1'b0;
    logic [7:0] file_bytes[$];

    jpeg_exif_segment_stripper_unit uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    jpeg_exif_segment_stripper_unit_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(0, 99) >= 12);
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL jpeg_exif_segment_stripper_unit");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic fin);
        while (!steady && $urandom_range(0, 99) < 12) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= {b, fin};
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
    endtask

    task automatic send_file();
        foreach (file_bytes[i]) begin
            send_byte(file_bytes[i], i == file_bytes.size() - 1);
        end
        sent += file_bytes.size();
    endtask

    // well-formed file: soi, a few segments, then eoi, sos data or a plain stop
    task automatic build_jpeg();
        int         len;
        int         pick;
        logic [7:0] id;
        logic [7:0] b;
        file_bytes = '{MARK_PREFIX, MARK_SOI};
        repeat ($urandom_range(1, 4)) begin
            pick = $urandom_range(0, 9);
            file_bytes.push_back(MARK_PREFIX);
            if (pick < 2) begin
                id = ($urandom_range(0, 3) == 0) ? MARK_TEM : MARK_RST0 + 8'($urandom_range(0, 7));
                file_bytes.push_back(id);
            end else begin
                if (pick < 6) begin
                    id  = MARK_APP1;
                    len = MIN_EXIF_LEN + $urandom_range(0, 4);
                end else if (pick < 7) begin
                    id  = MARK_APP1;
                    len = $urandom_range(2, 7);
                end else begin
                    id = 8'($urandom_range(0, 255));
                    if (id == MARK_EOI || id == MARK_SOS || id == MARK_TEM
                        || (id >= MARK_RST0 && id <= MARK_RST7)) begin
                        id = MARK_APP1 + 8'd1;
                    end
                    len = $urandom_range(2, 10);
                end
                file_bytes.push_back(id);
                file_bytes.push_back(8'(len >> 8));
                file_bytes.push_back(8'(len));
                for (int i = 2; i < len; i++) begin
                    if (pick < 6 && i < MIN_EXIF_LEN) begin
                        b = EXIF_SIG[i - 2];
                        if ($urandom_range(0, 15) == 0) begin
                            b = b ^ 8'(1 << $urandom_range(0, 7));
                        end
                    end else begin
                        b = 8'($urandom_range(0, 255));
                    end
                    file_bytes.push_back(b);
                end
            end
        end
        case ($urandom_range(0, 3))
            0: begin
                file_bytes.push_back(MARK_PREFIX);
                file_bytes.push_back(MARK_EOI);
            end
            1: begin
                file_bytes.push_back(MARK_PREFIX);
                file_bytes.push_back(MARK_EOI);
                repeat ($urandom_range(1, 3)) file_bytes.push_back(8'($urandom_range(0, 255)));
            end
            2: begin
                file_bytes.push_back(MARK_PREFIX);
                file_bytes.push_back(MARK_SOS);
                repeat ($urandom_range(2, 8)) file_bytes.push_back(8'($urandom_range(0, 255)));
            end
            default: begin
            end
        endcase
    endtask

    task automatic build_broken();
        int n;
        case ($urandom_range(0, 3))
            0: begin
                build_jpeg();
                n = $urandom_range(1, file_bytes.size() - 1);
                while (file_bytes.size() > n) begin
                    void'(file_bytes.pop_back());
                end
            end
            1: begin
                build_jpeg();
                n = $urandom_range(2, file_bytes.size() - 1);
                file_bytes[n] = 8'($urandom_range(0, 255));
            end
            2: begin
                file_bytes = '{MARK_PREFIX, MARK_SOI, MARK_PREFIX, MARK_APP1, 8'h00,
                               8'($urandom_range(0, 1))};
                repeat ($urandom_range(0, 3)) file_bytes.push_back(8'($urandom_range(0, 255)));
            end
            default: begin
                file_bytes = '{MARK_PREFIX, MARK_SOI, MARK_PREFIX, 8'hC0,
                               8'($urandom_range(1, 255)), 8'($urandom_range(0, 255))};
                repeat ($urandom_range(0, 4)) file_bytes.push_back(8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    task automatic build_plain();
        file_bytes = '{};
        file_bytes.push_back(8'($urandom_range(0, 255)));
        if (file_bytes[0] == MARK_PREFIX) begin
            file_bytes.push_back(MARK_SOI ^ 8'($urandom_range(1, 255)));
        end
        repeat ($urandom_range(0, 5)) file_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    initial begin
        int pick;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // lone prefix byte, soi only, non-jpeg
        file_bytes = '{MARK_PREFIX};
        send_file();
        file_bytes = '{MARK_PREFIX, MARK_SOI};
        send_file();
        file_bytes = '{8'h00, MARK_PREFIX};
        send_file();
        // missing prefix, then more bytes after the error
        file_bytes = '{MARK_PREFIX, MARK_SOI, 8'h00, MARK_PREFIX};
        send_file();
        // length word below two with header bytes held
        file_bytes = '{MARK_PREFIX, MARK_SOI, MARK_PREFIX, MARK_APP1, 8'h00, 8'h01};
        send_file();
        // standalone marker, then a file cut inside a length word
        file_bytes = '{MARK_PREFIX, MARK_SOI, MARK_PREFIX, MARK_RST7, MARK_PREFIX,
                       MARK_APP1, 8'hFF};
        send_file();

        while (sent < TOTAL_BYTES) begin
            steady = (sent >= 80 && sent < 130);
            pick   = $urandom_range(0, 99);
            if (pick < 70) begin
                build_jpeg();
            end else if (pick < 80) begin
                build_plain();
            end else begin
                build_broken();
            end
            send_file();
        end
        steady = 1'b0;
        s_valid <= 1'b0;

        @(posedge aclk);
        while (pending != 0) begin
            @(posedge aclk);
        end
        repeat (16) @(posedge aclk);

        if (mismatches == 0 && pending == 0) begin
            $display("PASS jpeg_exif_segment_stripper_unit");
        end else begin
            $display("FAIL jpeg_exif_segment_stripper_unit");
        end
        $finish;
    end

endmodule
